### design/fol_pkg.sv
// Shared types, constants and helper functions for the frequency-ordered list.
package fol_pkg;

  localparam int ENTRIES     = 16;
  localparam int COUNT_BITS  = 16;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_BITS    = $clog2(ENTRIES);
  localparam int OCC_BITS    = $clog2(ENTRIES + 1);
  localparam int STATUS_BITS = 2;
  localparam int POS_BITS    = 4;
  localparam int HIT_BITS    = 16;
  localparam int SEL_BITS    = 2;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOCATE = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_FULL      = 2'd2;

  // cell next-value source
  localparam logic [SEL_BITS-1:0] SEL_HOLD  = 2'd0;
  localparam logic [SEL_BITS-1:0] SEL_LEFT  = 2'd1;
  localparam logic [SEL_BITS-1:0] SEL_RIGHT = 2'd2;
  localparam logic [SEL_BITS-1:0] SEL_LOAD  = 2'd3;

  typedef struct packed {
    logic                         req_type;
    logic signed [VALUE_BITS-1:0] value;
  } fol_in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [POS_BITS-1:0]    position;
    logic [HIT_BITS-1:0]    hit_count;
  } fol_out_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
  } fol_entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [VALUE_BITS-1:0] key;
    logic [COUNT_BITS-1:0] thresh;
    logic [VALUE_BITS-1:0] ld_value;
    logic [COUNT_BITS-1:0] ld_count;
  } fol_bcast_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [IDX_BITS-1:0] first_set(input logic [ENTRIES-1:0] v);
    logic [IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_BITS'(i);
    end
    return idx;
  endfunction

endpackage

### design/fol_cell.sv
// One list slot: holds a value and its count, compares and shifts with its neighbors.
module fol_cell import fol_pkg::*; (
  input  logic                clk,
  input  fol_bcast_t          bcast,
  input  logic [SEL_BITS-1:0] sel,
  input  logic                valid,
  input  fol_entry_t          left_in,
  input  fol_entry_t          right_in,
  output fol_entry_t          entry,
  output logic                match,
  output logic                lt
);

  fol_entry_t entry_r;
  fol_entry_t entry_nxt;

  always_comb begin
    case (sel)
      SEL_HOLD:  entry_nxt = entry_r;
      SEL_LEFT:  entry_nxt = left_in;
      SEL_RIGHT: entry_nxt = right_in;
      SEL_LOAD:  entry_nxt = '{value: bcast.ld_value, count: bcast.ld_count};
      default:   entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = valid && (entry_r.value == bcast.key);
  assign lt    = valid && (entry_r.count < bcast.thresh);

endmodule

### design/frequency_ordered_list.sv
// Top level of the frequency-ordered list: controller plus a row of list cells.
//
//  channel | ports                          | payload   | direction
//  --------+--------------------------------+-----------+----------
//  input   | in_valid, in_stall, in_data    | fol_in_t  | in
//  result  | out_valid, out_stall, out_data | fol_out_t | out
//
// An insert (or a dropped insert, or a locate that misses) writes its result into
// the result register when its transfer is taken; a locate that hits first does
// the parallel compare in every cell and then the re-placing shift in ST_UPD.
// Reset (rst_n low, synchronous) empties the list; cell contents are not cleared.
// out_stall holds the result register; a new input is taken only in idle and
// only when the result register is empty or draining in that cycle.
module frequency_ordered_list import fol_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  fol_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output fol_out_t out_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                  state_r, state_nxt;
  logic [OCC_BITS-1:0]   occ_r, occ_nxt;
  logic [IDX_BITS-1:0]   found_r, found_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fol_out_t              out_data_r, out_data_nxt;

  fol_entry_t          cell_q   [ENTRIES];
  fol_entry_t          left_d   [ENTRIES];
  fol_entry_t          right_d  [ENTRIES];
  logic [SEL_BITS-1:0] sel      [ENTRIES];
  logic [ENTRIES-1:0]  valid_vec;
  logic [ENTRIES-1:0]  match_vec;
  logic [ENTRIES-1:0]  lt_vec;
  logic [ENTRIES-1:0]  lt_rest;
  fol_bcast_t          bcast;

  logic                  in_xfer;
  logic                  out_free;
  logic                  full;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [COUNT_BITS-1:0] hit_inc;
  logic [IDX_BITS-1:0]   lt_idx;
  logic [IDX_BITS-1:0]   dest;

  // ---------------- cell row ----------------
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign left_d[g] = '0;
      end else begin : g_mid_l
        assign left_d[g] = cell_q[g-1];
      end
      if (g == ENTRIES - 1) begin : g_last
        assign right_d[g] = '0;
      end else begin : g_mid_r
        assign right_d[g] = cell_q[g+1];
      end
      assign valid_vec[g] = OCC_BITS'(g) < occ_r;

      fol_cell u_cell (
        .clk      (clk),
        .bcast    (bcast),
        .sel      (sel[g]),
        .valid    (valid_vec[g]),
        .left_in  (left_d[g]),
        .right_in (right_d[g]),
        .entry    (cell_q[g]),
        .match    (match_vec[g]),
        .lt       (lt_vec[g])
      );
    end
  endgenerate

  // ---------------- handshake ----------------
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !rst_n || (state_r != ST_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign full     = occ_r == OCC_BITS'(ENTRIES);

  // compare phase: frontmost match and its bumped count (saturating)
  assign hit_idx = first_set(match_vec);
  assign hit_cnt = cell_q[hit_idx].count;
  assign hit_inc = (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;

  // shift phase: first remaining entry with a smaller count, found entry left out
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      lt_rest[k] = lt_vec[k] && (IDX_BITS'(k) != found_r);
    end
  end
  assign lt_idx = first_set(lt_rest);

  always_comb begin
    if (|lt_rest) begin
      // position in the list with the hit entry removed
      dest = (lt_idx < found_r) ? lt_idx : lt_idx - 1'b1;
    end else begin
      dest = IDX_BITS'(occ_r - 1'b1);
    end
  end

  always_comb begin
    bcast.key    = in_data.value;
    bcast.thresh = cnt_r;
    if (state_r == ST_UPD) begin
      bcast.ld_value = key_r;
      bcast.ld_count = cnt_r;
    end else begin
      bcast.ld_value = in_data.value;
      bcast.ld_count = '0;
    end
  end

  // per-cell source select
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      sel[k] = SEL_HOLD;
      if (state_r == ST_UPD) begin
        if (OCC_BITS'(k) < occ_r) begin
          if (IDX_BITS'(k) < dest) begin
            sel[k] = (IDX_BITS'(k) < found_r) ? SEL_HOLD : SEL_RIGHT;
          end else if (IDX_BITS'(k) == dest) begin
            sel[k] = SEL_LOAD;
          end else begin
            sel[k] = (IDX_BITS'(k) <= found_r) ? SEL_LEFT : SEL_HOLD;
          end
        end
      end else if (in_xfer && (in_data.req_type == REQ_INSERT) && !full) begin
        sel[k] = (k == 0) ? SEL_LOAD : SEL_LEFT;
      end
    end
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    found_nxt     = found_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.req_type == REQ_INSERT) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: full ? STAT_FULL : STAT_DONE,
                              position: '0, hit_count: '0};
            if (!full) occ_nxt = occ_r + 1'b1;
          end else if (|match_vec) begin
            state_nxt = ST_UPD;
            found_nxt = hit_idx;
            cnt_nxt   = hit_inc;
            key_nxt   = in_data.value;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: STAT_NOT_FOUND, position: '0, hit_count: '0};
          end
        end
      end
      ST_UPD: begin
        // result register was emptied when this locate was taken
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: STAT_DONE, position: POS_BITS'(dest),
                          hit_count: HIT_BITS'(cnt_r)};
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    found_r    <= found_nxt;
    cnt_r      <= cnt_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  a_upd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (state_r == ST_IDLE))
    else $error("shift phase lasted more than one cycle");

  a_upd_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> !out_valid_r)
    else $error("result register busy during shift phase");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (OCC_BITS'(found_r) < occ_r))
    else $error("hit index beyond occupancy");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |-> (occ_r == $past(occ_r) + 1'b1))
    else $error("occupancy changed by other than one insert");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(full) && $past(rst_n) |-> full)
    else $error("full list lost entries");

endmodule
